// ===== design/dqfb_pkg.sv =====
// Shared types and constants for the DNS / NetBIOS name-query frame builder.
// Used by every module of the block; depends on nothing else.
package dqfb_pkg;

  // Configuration register indexes.
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_NAME_MODE    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_QUERY_ID     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HEADER_FLAGS = 2'd2;

  // Register reset values.
  localparam logic        NAME_MODE_RST    = 1'b0;
  localparam logic [15:0] QUERY_ID_RST     = 16'h0001;
  localparam logic [15:0] HEADER_FLAGS_RST = 16'h0110;

  // Character constants.
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_CASE    = 8'h20;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_C = 8'h43;
  localparam logic [7:0] NB_NAME_LEN = 8'h20;

  // NetBIOS names hold at most this many characters.
  localparam logic [3:0] NB_MAX_CHARS = 4'd15;

  // Sequencer index width and command queue depth.
  localparam int IdxW      = 6;
  localparam int QueueDepth = 4;
  localparam int QPtrW      = 2;
  localparam int QCntW      = 3;

  // Last header byte index (DNS, NetBIOS adds the name length byte).
  localparam logic [IdxW-1:0] HDR_LAST_DNS = 6'd11;
  localparam logic [IdxW-1:0] HDR_LAST_NB  = 6'd12;
  localparam logic [IdxW-1:0] TAIL_LAST_DNS = 6'd4;
  localparam logic [IdxW-1:0] TAIL_LAST_NB  = 6'd6;

  // Command kinds produced by the front end.
  typedef enum logic [2:0] {
    K_DNS_CHAR,
    K_DNS_DOT,
    K_DNS_END,
    K_NB_CHAR,
    K_NB_END
  } kind_t;

  // One classified input word.
  typedef struct packed {
    logic       hdr;
    kind_t      kind;
    logic [7:0] ch;
  } cmd_t;

  // One message byte from the sequencer to the packer.
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       last;
    logic       fin;
    logic       ovf;
  } msg_byte_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_STORE,
    S_FLEN,
    S_FDATA,
    S_TAIL,
    S_NBC,
    S_PAD
  } seq_state_t;

endpackage

// ===== design/dqfb_front.sv =====
// Front end: accepts input words, drops null characters and classifies the rest.
// Depends on dqfb_pkg; feeds dqfb_queue.
module dqfb_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_name_byte,
  input  logic            in_end_of_name,
  input  logic            name_mode,
  input  logic            q_full,
  output logic            push,
  output dqfb_pkg::cmd_t  push_cmd
);

  logic hsent_r;
  logic hsent_nxt;
  logic ignore;

  // A null character carries nothing and is dropped here.
  assign ignore   = !in_end_of_name && (in_name_byte == 8'h00);
  assign in_stall = q_full;
  assign push     = in_valid && !q_full && !ignore;

  // Classify the word by mode and character. Only NetBIOS names are uppercased.
  always_comb begin
    push_cmd.hdr = !hsent_r;
    push_cmd.ch  = in_name_byte;
    if (name_mode &&
        (in_name_byte inside {[dqfb_pkg::CH_LOWER_A:dqfb_pkg::CH_LOWER_Z]})) begin
      push_cmd.ch = in_name_byte - dqfb_pkg::CH_CASE;
    end
    if (in_end_of_name) begin
      push_cmd.kind = name_mode ? dqfb_pkg::K_NB_END : dqfb_pkg::K_DNS_END;
    end else if (name_mode) begin
      push_cmd.kind = dqfb_pkg::K_NB_CHAR;
    end else if (in_name_byte == dqfb_pkg::CH_DOT) begin
      push_cmd.kind = dqfb_pkg::K_DNS_DOT;
    end else begin
      push_cmd.kind = dqfb_pkg::K_DNS_CHAR;
    end
  end

  // The header goes out with the first word of a message.
  always_comb begin
    hsent_nxt = hsent_r;
    if (push) begin
      hsent_nxt = !in_end_of_name;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hsent_r <= 1'b0;
    end else begin
      hsent_r <= hsent_nxt;
    end
  end

endmodule

// ===== design/dqfb_queue.sv =====
// Short command queue between the front end and the sequencer.
// Depends on dqfb_pkg for the command type and depth.
module dqfb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dqfb_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            vld,
  output dqfb_pkg::cmd_t  head
);

  dqfb_pkg::cmd_t                  slot_r [dqfb_pkg::QueueDepth];
  logic [dqfb_pkg::QPtrW-1:0]      wptr_r;
  logic [dqfb_pkg::QPtrW-1:0]      rptr_r;
  logic [dqfb_pkg::QCntW-1:0]      cnt_r;
  logic [dqfb_pkg::QPtrW-1:0]      wptr_nxt;
  logic [dqfb_pkg::QPtrW-1:0]      rptr_nxt;
  logic [dqfb_pkg::QCntW-1:0]      cnt_nxt;

  assign full = (cnt_r == dqfb_pkg::QCntW'(dqfb_pkg::QueueDepth));
  assign vld  = (cnt_r != '0);
  assign head = slot_r[rptr_r];

  // Pointer and fill count update.
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

endmodule

// ===== design/dqfb_seq.sv =====
// Back end sequencer: runs commands, emits message bytes one per cycle on go.
// Holds the label memory and name state; depends on dqfb_pkg, feeds dqfb_pack.
module dqfb_seq #(
  parameter int LABEL_CAP = 63
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_vld,
  input  dqfb_pkg::cmd_t      q_head,
  output logic                q_pop,
  input  logic [15:0]         query_id,
  input  logic [15:0]         header_flags,
  input  logic                go,
  output dqfb_pkg::msg_byte_t byte_o
);

  localparam int LenW  = $clog2(LABEL_CAP + 1);
  localparam int AddrW = $clog2(LABEL_CAP);

  dqfb_pkg::seq_state_t     state_r;
  dqfb_pkg::seq_state_t     state_nxt;
  dqfb_pkg::cmd_t           cmd_r;
  logic [dqfb_pkg::IdxW-1:0] idx_r;
  logic [dqfb_pkg::IdxW-1:0] idx_nxt;
  logic [dqfb_pkg::IdxW-1:0] idx_inc;
  logic [LenW-1:0]          len_r;
  logic [LenW-1:0]          len_nxt;
  logic [3:0]               nbc_r;
  logic [3:0]               nbc_nxt;
  logic                     ovf_r;
  logic                     ovf_nxt;
  logic [7:0]               label_mem [LABEL_CAP];
  logic [7:0]               rd_data_r;
  logic                     wr_en;
  logic                     rd_en;
  logic [AddrW-1:0]         rd_addr;
  logic                     nb;
  logic                     len_zero;
  logic                     nb_full;
  logic                     body_empty;
  logic                     label_done;
  logic [dqfb_pkg::IdxW-1:0] hdr_last;
  logic [dqfb_pkg::IdxW-1:0] tail_last;

  // Header byte at a given position.
  function automatic logic [7:0] hdr_byte(input logic [dqfb_pkg::IdxW-1:0] i,
                                          input logic [15:0] qid,
                                          input logic [15:0] flags);
    logic [7:0] b;
    case (i)
      6'd0:    b = qid[15:8];
      6'd1:    b = qid[7:0];
      6'd2:    b = flags[15:8];
      6'd3:    b = flags[7:0];
      6'd5:    b = 8'h01;
      6'd12:   b = dqfb_pkg::NB_NAME_LEN;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Closing bytes: NetBIOS final AA pair, then root label, type and class.
  function automatic logic [7:0] tail_byte(input logic is_nb,
                                           input logic [dqfb_pkg::IdxW-1:0] i);
    logic [7:0] b;
    b = 8'h00;
    if (is_nb) begin
      case (i)
        6'd0, 6'd1: b = dqfb_pkg::CH_UPPER_A;
        6'd4:       b = 8'h20;
        6'd6:       b = 8'h01;
        default:    b = 8'h00;
      endcase
    end else begin
      case (i)
        6'd2, 6'd4: b = 8'h01;
        default:    b = 8'h00;
      endcase
    end
    return b;
  endfunction

  // First body state of a command kind.
  function automatic dqfb_pkg::seq_state_t body_state(input dqfb_pkg::kind_t k);
    dqfb_pkg::seq_state_t s;
    case (k)
      dqfb_pkg::K_DNS_CHAR: s = dqfb_pkg::S_STORE;
      dqfb_pkg::K_DNS_DOT:  s = dqfb_pkg::S_FLEN;
      dqfb_pkg::K_DNS_END:  s = dqfb_pkg::S_FLEN;
      dqfb_pkg::K_NB_CHAR:  s = dqfb_pkg::S_NBC;
      dqfb_pkg::K_NB_END:   s = dqfb_pkg::S_PAD;
      default:              s = dqfb_pkg::S_IDLE;
    endcase
    return s;
  endfunction

  assign nb         = (cmd_r.kind == dqfb_pkg::K_NB_CHAR) ||
                      (cmd_r.kind == dqfb_pkg::K_NB_END);
  assign len_zero   = (len_r == '0);
  assign nb_full    = (nbc_r == dqfb_pkg::NB_MAX_CHARS);
  assign idx_inc    = idx_r + 1'b1;
  assign label_done = (idx_inc == dqfb_pkg::IdxW'(len_r));
  assign hdr_last   = nb ? dqfb_pkg::HDR_LAST_NB : dqfb_pkg::HDR_LAST_DNS;
  assign tail_last  = nb ? dqfb_pkg::TAIL_LAST_NB : dqfb_pkg::TAIL_LAST_DNS;
  assign q_pop      = (state_r == dqfb_pkg::S_IDLE) && q_vld;

  // The body adds no bytes when it only stores, flushes nothing or drops.
  assign body_empty = (cmd_r.kind == dqfb_pkg::K_DNS_CHAR) ||
                      ((cmd_r.kind == dqfb_pkg::K_DNS_DOT) && len_zero) ||
                      ((cmd_r.kind == dqfb_pkg::K_NB_CHAR) && nb_full);

  // Byte output for the current state.
  always_comb begin
    byte_o = '0;
    case (state_r)
      dqfb_pkg::S_HDR: begin
        byte_o.vld  = 1'b1;
        byte_o.data = hdr_byte(idx_r, query_id, header_flags);
        byte_o.last = (idx_r == hdr_last) && body_empty;
      end
      dqfb_pkg::S_FLEN: begin
        byte_o.vld  = !len_zero;
        byte_o.data = 8'(len_r);
      end
      dqfb_pkg::S_FDATA: begin
        byte_o.vld  = 1'b1;
        byte_o.data = rd_data_r;
        byte_o.last = label_done && (cmd_r.kind == dqfb_pkg::K_DNS_DOT);
      end
      dqfb_pkg::S_TAIL: begin
        byte_o.vld  = 1'b1;
        byte_o.data = tail_byte(nb, idx_r);
        byte_o.last = (idx_r == tail_last);
        byte_o.fin  = (idx_r == tail_last);
        byte_o.ovf  = (idx_r == tail_last) && ovf_r;
      end
      dqfb_pkg::S_NBC: begin
        byte_o.vld  = !nb_full;
        byte_o.data = idx_r[0] ? (dqfb_pkg::CH_UPPER_A + {4'h0, cmd_r.ch[3:0]})
                               : (dqfb_pkg::CH_UPPER_A + {4'h0, cmd_r.ch[7:4]});
        byte_o.last = idx_r[0];
      end
      dqfb_pkg::S_PAD: begin
        byte_o.vld  = !nb_full;
        byte_o.data = idx_r[0] ? dqfb_pkg::CH_UPPER_A : dqfb_pkg::CH_UPPER_C;
      end
      default: begin
        byte_o = '0;
      end
    endcase
  end

  // Next state and byte index.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      dqfb_pkg::S_IDLE: begin
        if (q_vld) begin
          state_nxt = q_head.hdr ? dqfb_pkg::S_HDR : body_state(q_head.kind);
          idx_nxt   = '0;
        end
      end
      dqfb_pkg::S_HDR: begin
        if (go) begin
          if (idx_r == hdr_last) begin
            state_nxt = body_state(cmd_r.kind);
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_inc;
          end
        end
      end
      dqfb_pkg::S_STORE: begin
        state_nxt = dqfb_pkg::S_IDLE;
      end
      dqfb_pkg::S_FLEN: begin
        if (len_zero) begin
          state_nxt = (cmd_r.kind == dqfb_pkg::K_DNS_END) ? dqfb_pkg::S_TAIL
                                                          : dqfb_pkg::S_IDLE;
          idx_nxt   = '0;
        end else if (go) begin
          state_nxt = dqfb_pkg::S_FDATA;
          idx_nxt   = '0;
        end
      end
      dqfb_pkg::S_FDATA: begin
        if (go) begin
          if (label_done) begin
            state_nxt = (cmd_r.kind == dqfb_pkg::K_DNS_END) ? dqfb_pkg::S_TAIL
                                                            : dqfb_pkg::S_IDLE;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_inc;
          end
        end
      end
      dqfb_pkg::S_TAIL: begin
        if (go) begin
          if (idx_r == tail_last) begin
            state_nxt = dqfb_pkg::S_IDLE;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_inc;
          end
        end
      end
      dqfb_pkg::S_NBC: begin
        if (nb_full) begin
          state_nxt = dqfb_pkg::S_IDLE;
        end else if (go) begin
          if (idx_r[0]) begin
            state_nxt = dqfb_pkg::S_IDLE;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_inc;
          end
        end
      end
      dqfb_pkg::S_PAD: begin
        if (nb_full) begin
          state_nxt = dqfb_pkg::S_TAIL;
          idx_nxt   = '0;
        end else if (go) begin
          idx_nxt = idx_inc;
        end
      end
      default: begin
        state_nxt = dqfb_pkg::S_IDLE;
        idx_nxt   = '0;
      end
    endcase
  end

  // Name state, label memory writes and prefetch reads.
  always_comb begin
    len_nxt = len_r;
    nbc_nxt = nbc_r;
    ovf_nxt = ovf_r;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state_r)
      dqfb_pkg::S_STORE: begin
        if (len_r < LenW'(LABEL_CAP)) begin
          wr_en   = 1'b1;
          len_nxt = len_r + 1'b1;
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      dqfb_pkg::S_FLEN: begin
        rd_en = go && !len_zero;
      end
      dqfb_pkg::S_FDATA: begin
        if (go) begin
          if (label_done) begin
            len_nxt = '0;
          end else begin
            rd_en   = 1'b1;
            rd_addr = AddrW'(idx_inc);
          end
        end
      end
      dqfb_pkg::S_TAIL: begin
        if (go && (idx_r == tail_last)) begin
          len_nxt = '0;
          nbc_nxt = '0;
          ovf_nxt = 1'b0;
        end
      end
      dqfb_pkg::S_NBC: begin
        if (nb_full) begin
          ovf_nxt = 1'b1;
        end else if (go && idx_r[0]) begin
          nbc_nxt = nbc_r + 1'b1;
        end
      end
      dqfb_pkg::S_PAD: begin
        if (!nb_full && go && idx_r[0]) begin
          nbc_nxt = nbc_r + 1'b1;
        end
      end
      default: begin
        len_nxt = len_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dqfb_pkg::S_IDLE;
      idx_r   <= '0;
      len_r   <= '0;
      nbc_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
      nbc_r   <= nbc_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Current command register.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_head;
    end
  end

  // Label memory: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      label_mem[len_r[AddrW-1:0]] <= cmd_r.ch;
    end
    if (rd_en) begin
      rd_data_r <= label_mem[rd_addr];
    end
  end

endmodule

// ===== design/dqfb_pack.sv =====
// Output packer: pairs message bytes of one word and holds the result register.
// Depends on dqfb_pkg; driven by dqfb_seq.
module dqfb_pack (
  input  logic                clk,
  input  logic                rst_n,
  input  dqfb_pkg::msg_byte_t byte_i,
  output logic                go,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_first_byte,
  output logic [7:0]          out_second_byte,
  output logic                out_pair_valid,
  output logic                out_message_end,
  output logic                out_label_overflow
);

  logic       hold_vld_r;
  logic       hold_vld_nxt;
  logic [7:0] hold_r;
  logic       out_vld_r;
  logic       out_vld_nxt;
  logic       emit;
  logic       load_ok;
  logic       load;

  // A word is sent when a pair is complete or the item ends on an odd byte.
  assign emit    = byte_i.vld && (hold_vld_r || byte_i.last);
  assign load_ok = !out_vld_r || !out_stall;
  assign go      = !emit || load_ok;
  assign load    = emit && load_ok;

  assign out_valid = out_vld_r;

  always_comb begin
    hold_vld_nxt = hold_vld_r;
    if (byte_i.vld && go) begin
      hold_vld_nxt = !emit;
    end
    out_vld_nxt = out_vld_r;
    if (load) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Held byte and result payload.
  always_ff @(posedge clk) begin
    if (byte_i.vld && go && !emit) begin
      hold_r <= byte_i.data;
    end
    if (load) begin
      out_first_byte     <= hold_vld_r ? hold_r : byte_i.data;
      out_second_byte    <= hold_vld_r ? byte_i.data : 8'h00;
      out_pair_valid     <= hold_vld_r;
      out_message_end    <= byte_i.fin;
      out_label_overflow <= byte_i.ovf;
    end
  end

endmodule

// ===== design/dns_query_frame_builder.sv =====
// DNS / NetBIOS name-query frame builder, top level.
// Holds the configuration registers and connects front end, queue, sequencer and packer.
// Depends on dqfb_pkg and all dqfb_* modules.
//
// Usage: feed a host name one character per input word (in_valid/in_stall),
// closed by a word with in_end_of_name set. Null characters are dropped.
// Each result word (out_valid/out_stall) carries one or two message bytes:
// first the 12-byte header (NetBIOS adds the 0x20 length byte), then the
// encoded name, the root byte, type and class. out_message_end marks the
// word with the class byte; out_label_overflow there reports dropped chars.
// Configuration (cfg_we, cfg_index, cfg_wdata) is to be written while idle;
// the block itself does not enforce this. Timing: an input word enters a
// 4-deep command queue. The sequencer takes a command in its idle state,
// then emits its message bytes one per cycle unless the packer stalls it;
// a step that sends nothing has its own state: storing a DNS character, an
// empty label, a character past a full NetBIOS name, or the end of the
// padding. A dot flushes the buffered label at one byte per cycle when not
// stalled, set by the single read port of the label memory. When the
// receiver stalls, the output register holds, the sequencer pauses once it
// has a word to send, and the queue keeps taking words until full, then
// in_stall rises.
// Reset restores the register defaults and empties queue and name state;
// the label memory is not cleared (it is read only after being written).
module dns_query_frame_builder #(
  parameter int LABEL_MAX = 63
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_name_byte,
  input  logic                         in_end_of_name,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_first_byte,
  output logic [7:0]                   out_second_byte,
  output logic                         out_pair_valid,
  output logic                         out_message_end,
  output logic                         out_label_overflow,
  input  logic                         cfg_we,
  input  logic [dqfb_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [15:0]                  cfg_wdata
);

  localparam int LabelCap = (LABEL_MAX < 63) ? LABEL_MAX : 63;

  logic                name_mode_r;
  logic [15:0]         query_id_r;
  logic [15:0]         header_flags_r;
  logic                push;
  dqfb_pkg::cmd_t      push_cmd;
  logic                q_full;
  logic                q_pop;
  logic                q_vld;
  dqfb_pkg::cmd_t      q_head;
  logic                go;
  dqfb_pkg::msg_byte_t msg_byte;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_mode_r    <= dqfb_pkg::NAME_MODE_RST;
      query_id_r     <= dqfb_pkg::QUERY_ID_RST;
      header_flags_r <= dqfb_pkg::HEADER_FLAGS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dqfb_pkg::CFG_NAME_MODE:    name_mode_r    <= cfg_wdata[0];
        dqfb_pkg::CFG_QUERY_ID:     query_id_r     <= cfg_wdata;
        dqfb_pkg::CFG_HEADER_FLAGS: header_flags_r <= cfg_wdata;
        default:                    name_mode_r    <= name_mode_r;
      endcase
    end
  end

  dqfb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_name_byte   (in_name_byte),
    .in_end_of_name (in_end_of_name),
    .name_mode      (name_mode_r),
    .q_full         (q_full),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  dqfb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .vld      (q_vld),
    .head     (q_head)
  );

  dqfb_seq #(
    .LABEL_CAP (LabelCap)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_vld        (q_vld),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .query_id     (query_id_r),
    .header_flags (header_flags_r),
    .go           (go),
    .byte_o       (msg_byte)
  );

  dqfb_pack u_pack (
    .clk                (clk),
    .rst_n              (rst_n),
    .byte_i             (msg_byte),
    .go                 (go),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_first_byte     (out_first_byte),
    .out_second_byte    (out_second_byte),
    .out_pair_valid     (out_pair_valid),
    .out_message_end    (out_message_end),
    .out_label_overflow (out_label_overflow)
  );

endmodule
